>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules of the two-axis line stepper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TALS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An antecedent that implies a consequent in the same cycle.
`define TALS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that implies a consequent in the next cycle.
`define TALS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tals_pkg.sv
// Package with the widths, codes, types and helper functions of the two-axis line stepper.
package tals_pkg;

  localparam int POS_W      = 24;
  localparam int TGT_W      = 24;
  localparam int SPEED_W    = 16;
  localparam int DIST_W     = 16;
  localparam int LEN_W      = DIST_W - 1;
  localparam int PROD_W     = SPEED_W + LEN_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic        [POS_W-1:0]      pos_t;
  typedef logic        [POS_W:0]        pos_ext_t;
  typedef logic signed [POS_W-1:0]      spos_t;
  typedef logic signed [POS_W:0]        spos_ext_t;
  typedef logic signed [TGT_W-1:0]      tgt_t;
  typedef logic        [SPEED_W-1:0]    speed_t;
  typedef logic        [SPEED_W:0]      speed_ext_t;
  typedef logic        [DIST_W-1:0]     dist_t;
  typedef logic        [LEN_W-1:0]      len_t;
  typedef logic        [LEN_W:0]        len_ext_t;
  typedef logic        [PROD_W-1:0]     prod_t;
  typedef logic        [DIV_CNT_W-1:0]  div_cnt_t;
  typedef logic        [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_W-1:0] cfg_data_t;

  localparam pos_t     POS_ONE      = pos_t'(1);
  localparam speed_t   SPEED_ONE    = speed_t'(1);
  localparam div_cnt_t DIV_CNT_LAST = div_cnt_t'(PROD_W - 1);

  localparam speed_t RST_MAX_SPEED   = speed_t'(1000);
  localparam speed_t RST_START_SPEED = speed_t'(100);
  localparam speed_t RST_DWELL_SPEED = speed_t'(100);
  localparam dist_t  RST_SHORT_DIST  = dist_t'(200);

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_IDLE     = 2'd0,
    STATUS_STEPPING = 2'd1,
    STATUS_LAST     = 2'd2,
    STATUS_REJECTED = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAMP_ENABLE    = 3'd0,
    REG_MAX_SPEED      = 3'd1,
    REG_START_SPEED    = 3'd2,
    REG_DWELL_SPEED    = 3'd3,
    REG_SHORT_DISTANCE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic    capture;
    logic    calc_dist;
    logic    select;
    logic    restore;
    logic    accum;
    logic    classify;
    logic    mul;
    logic    div_step;
    logic    ramp_set;
    logic    step;
    logic    load_out;
    status_e out_status;
    logic    out_steps;
  } dp_cmd_t;

  typedef struct packed {
    logic major_zero;
    logic ramp_needed;
    logic div_last;
    logic last_step;
    logic out_free;
  } dp_sts_t;

  function automatic speed_t at_least_one(speed_t v);
    return (v == '0) ? SPEED_ONE : v;
  endfunction

endpackage

>>> rtl/tals_if.sv
// Handshake interfaces for the input items and the result items of the line stepper.
interface tals_in_if;
  logic              valid;
  logic              ready;
  logic              opcode;
  tals_pkg::tgt_t    target_first;
  tals_pkg::tgt_t    target_second;

  modport source (output valid, output opcode, output target_first, output target_second,
                  input ready);
  modport sink (input valid, input opcode, input target_first, input target_second,
                output ready);
endinterface

interface tals_out_if;
  logic              valid;
  logic              ready;
  logic              step_first;
  logic              step_second;
  logic              dir_first;
  logic              dir_second;
  tals_pkg::speed_t  speed;
  logic [1:0]        status;

  modport source (output valid, output step_first, output step_second, output dir_first,
                  output dir_second, output speed, output status, input ready);
  modport sink (input valid, input step_first, input step_second, input dir_first,
                input dir_second, input speed, input status, output ready);
endinterface

>>> rtl/tals_ctrl.sv
// Controller state machine that sequences starts, ticks, the ramp divider and result hand-off.
`include "assert_macros.svh"

module tals_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_opcode_i,
  output logic              in_ready_o,
  input  tals_pkg::dp_sts_t sts_i,
  output tals_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST,
    ST_SELECT,
    ST_START_END,
    ST_ACCUM,
    ST_CLASSIFY,
    ST_MUL,
    ST_DIV,
    ST_RAMP_SET,
    ST_STEP,
    ST_RESULT
  } state_e;

  state_e            state_q, state_d;
  logic              busy_q, busy_d;
  tals_pkg::status_e res_status_q, res_status_d;
  logic              res_steps_q, res_steps_d;

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    res_status_d = res_status_q;
    res_steps_d  = res_steps_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          res_steps_d   = 1'b0;
          if (in_opcode_i == tals_pkg::OP_START) begin
            if (busy_q) begin
              res_status_d = tals_pkg::STATUS_REJECTED;
              state_d      = ST_RESULT;
            end else begin
              state_d = ST_DIST;
            end
          end else if (busy_q) begin
            state_d = ST_ACCUM;
          end else begin
            res_status_d = tals_pkg::STATUS_IDLE;
            state_d      = ST_RESULT;
          end
        end
      end
      ST_DIST: begin
        cmd_o.calc_dist = 1'b1;
        state_d         = ST_SELECT;
      end
      ST_SELECT: begin
        cmd_o.select = 1'b1;
        state_d      = ST_START_END;
      end
      ST_START_END: begin
        if (sts_i.major_zero) begin
          cmd_o.restore = 1'b1;
          res_status_d  = tals_pkg::STATUS_IDLE;
        end else begin
          busy_d       = 1'b1;
          res_status_d = tals_pkg::STATUS_STEPPING;
        end
        state_d = ST_RESULT;
      end
      ST_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        state_d        = sts_i.ramp_needed ? ST_MUL : ST_RAMP_SET;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_RAMP_SET;
        end
      end
      ST_RAMP_SET: begin
        cmd_o.ramp_set = 1'b1;
        state_d        = ST_STEP;
      end
      ST_STEP: begin
        cmd_o.step  = 1'b1;
        res_steps_d = 1'b1;
        if (sts_i.last_step) begin
          busy_d       = 1'b0;
          res_status_d = tals_pkg::STATUS_LAST;
        end else begin
          res_status_d = tals_pkg::STATUS_STEPPING;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out   = 1'b1;
          cmd_o.restore    = (res_status_q == tals_pkg::STATUS_LAST);
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    cmd_o.out_status = res_status_q;
    cmd_o.out_steps  = res_steps_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      busy_q       <= 1'b0;
      res_status_q <= tals_pkg::STATUS_IDLE;
      res_steps_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      busy_q       <= busy_d;
      res_status_q <= res_status_d;
      res_steps_q  <= res_steps_d;
    end
  end

  `TALS_ASSERT_IMPL(a_load_when_free, clk_i, rst_ni, cmd_o.load_out, sts_i.out_free, "result loaded over an untaken result")
  `TALS_ASSERT_IMPL(a_busy_from_start, clk_i, rst_ni, $rose(busy_q), $past(state_q) == ST_START_END, "move began outside a start")
  `TALS_ASSERT_NEXT(a_step_to_result, clk_i, rst_ni, state_q == ST_STEP, state_q == ST_RESULT && res_steps_q, "step did not lead to a stepping result")

endmodule

>>> rtl/tals_dp.sv
// Datapath with configuration registers, Bresenham stepping, ramp divider and result register.
`include "assert_macros.svh"

module tals_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  tals_pkg::cfg_idx_t   cfg_idx_i,
  input  tals_pkg::cfg_data_t  cfg_data_i,
  input  tals_pkg::tgt_t       target_first_i,
  input  tals_pkg::tgt_t       target_second_i,
  input  tals_pkg::dp_cmd_t    cmd_i,
  output tals_pkg::dp_sts_t    sts_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 out_step_first_o,
  output logic                 out_step_second_o,
  output logic                 out_dir_first_o,
  output logic                 out_dir_second_o,
  output tals_pkg::speed_t     out_speed_o,
  output logic [1:0]           out_status_o
);

  typedef enum logic [1:0] {
    RM_NONE,
    RM_DWELL,
    RM_MAX,
    RM_RAMP
  } ramp_mode_e;

  // Configuration registers.
  logic                ramp_en_q;
  tals_pkg::speed_t    max_q, start_q, dwell_q;
  tals_pkg::dist_t     sd_q;

  // Move state.
  tals_pkg::pos_t      pos1_q, pos2_q;
  tals_pkg::pos_t      major_q, minor_q, idx_q;
  tals_pkg::pos_ext_t  err_q;
  logic                second_major_q;
  logic [1:0]          dirs_q;
  tals_pkg::speed_t    cur_speed_q;

  // Working registers.
  tals_pkg::tgt_t      tgt1_q, tgt2_q;
  tals_pkg::pos_t      dist1_q, dist2_q;
  logic [1:0]          dir_new_q;
  tals_pkg::pos_ext_t  err_sum_q;
  tals_pkg::pos_t      rem_q;
  logic                up_q, short_q;
  ramp_mode_e          mode_q, mode_d;
  tals_pkg::len_t      k_q, k_d;
  logic                neg_q, neg_d;
  tals_pkg::speed_t    absdiff_q, absdiff_d;
  tals_pkg::len_ext_t  div_rem_q;
  tals_pkg::prod_t     div_quo_q;
  tals_pkg::div_cnt_t  div_cnt_q;
  logic                step1_q, step2_q;

  // Result register.
  logic                out_valid_q;
  logic                out_step1_q, out_step2_q, out_dir1_q, out_dir2_q;
  tals_pkg::speed_t    out_speed_q;
  tals_pkg::status_e   out_status_q;

  tals_pkg::len_t      len;
  tals_pkg::speed_t    hi, lo;
  tals_pkg::spos_t     t1, t2, p1, p2;
  tals_pkg::spos_ext_t d1, d2, nd1, nd2;
  logic                down;
  tals_pkg::len_ext_t  trial;
  logic                trial_ge;
  tals_pkg::speed_ext_t ramp_sum;
  tals_pkg::speed_t    quo;
  logic                minor_step;
  logic                s1, s2;

  assign len = sd_q[tals_pkg::DIST_W-1:1];
  assign hi  = tals_pkg::at_least_one(max_q);
  assign lo  = tals_pkg::at_least_one(start_q);

  // Signed distances to the targets, both ways round, so that the magnitude is a select.
  always_comb begin
    t1  = tals_pkg::spos_t'(tgt1_q);
    t2  = tals_pkg::spos_t'(tgt2_q);
    p1  = tals_pkg::spos_t'(pos1_q);
    p2  = tals_pkg::spos_t'(pos2_q);
    d1  = tals_pkg::spos_ext_t'(t1) - tals_pkg::spos_ext_t'(p1);
    d2  = tals_pkg::spos_ext_t'(t2) - tals_pkg::spos_ext_t'(p2);
    nd1 = tals_pkg::spos_ext_t'(p1) - tals_pkg::spos_ext_t'(t1);
    nd2 = tals_pkg::spos_ext_t'(p2) - tals_pkg::spos_ext_t'(t2);
  end

  always_comb begin
    down = (rem_q <= tals_pkg::pos_t'(len));
    k_d  = up_q ? idx_q[tals_pkg::LEN_W-1:0] : rem_q[tals_pkg::LEN_W-1:0];
    neg_d     = (hi < lo);
    absdiff_d = neg_d ? (lo - hi) : (hi - lo);
    priority if (!ramp_en_q) begin
      mode_d = RM_NONE;
    end else if (short_q) begin
      mode_d = (idx_q == '0) ? RM_DWELL : RM_NONE;
    end else if (len == '0) begin
      mode_d = RM_MAX;
    end else if (up_q || down) begin
      mode_d = RM_RAMP;
    end else begin
      mode_d = RM_NONE;
    end
  end

  always_comb begin
    trial    = {div_rem_q[tals_pkg::LEN_W-1:0], div_quo_q[tals_pkg::PROD_W-1]};
    trial_ge = (trial >= tals_pkg::len_ext_t'(len));
    quo      = div_quo_q[tals_pkg::SPEED_W-1:0];
    if (neg_q) begin
      ramp_sum = tals_pkg::speed_ext_t'(lo) - tals_pkg::speed_ext_t'(quo)
               - tals_pkg::speed_ext_t'(div_rem_q != '0);
    end else begin
      ramp_sum = tals_pkg::speed_ext_t'(lo) + tals_pkg::speed_ext_t'(quo);
    end
  end

  always_comb begin
    minor_step = (err_sum_q >= tals_pkg::pos_ext_t'(major_q));
    s1         = second_major_q ? minor_step : 1'b1;
    s2         = second_major_q ? 1'b1 : minor_step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ramp_en_q <= 1'b1;
      max_q     <= tals_pkg::RST_MAX_SPEED;
      start_q   <= tals_pkg::RST_START_SPEED;
      dwell_q   <= tals_pkg::RST_DWELL_SPEED;
      sd_q      <= tals_pkg::RST_SHORT_DIST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tals_pkg::REG_RAMP_ENABLE:    ramp_en_q <= cfg_data_i[0];
        tals_pkg::REG_MAX_SPEED:      max_q     <= cfg_data_i[tals_pkg::SPEED_W-1:0];
        tals_pkg::REG_START_SPEED:    start_q   <= cfg_data_i[tals_pkg::SPEED_W-1:0];
        tals_pkg::REG_DWELL_SPEED:    dwell_q   <= cfg_data_i[tals_pkg::SPEED_W-1:0];
        tals_pkg::REG_SHORT_DISTANCE: sd_q      <= cfg_data_i[tals_pkg::DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos1_q         <= '0;
      pos2_q         <= '0;
      major_q        <= '0;
      minor_q        <= '0;
      err_q          <= '0;
      idx_q          <= '0;
      second_major_q <= 1'b0;
      dirs_q         <= '0;
    end else if (cmd_i.select) begin
      if (dist1_q > dist2_q) begin
        second_major_q <= 1'b0;
        major_q        <= dist1_q;
        minor_q        <= dist2_q;
      end else begin
        second_major_q <= 1'b1;
        major_q        <= dist2_q;
        minor_q        <= dist1_q;
      end
      dirs_q <= dir_new_q;
      err_q  <= '0;
      idx_q  <= '0;
    end else if (cmd_i.step) begin
      err_q <= minor_step ? (err_sum_q - tals_pkg::pos_ext_t'(major_q)) : err_sum_q;
      idx_q <= idx_q + tals_pkg::POS_ONE;
      if (s1) begin
        pos1_q <= dirs_q[0] ? (pos1_q + tals_pkg::POS_ONE) : (pos1_q - tals_pkg::POS_ONE);
      end
      if (s2) begin
        pos2_q <= dirs_q[1] ? (pos2_q + tals_pkg::POS_ONE) : (pos2_q - tals_pkg::POS_ONE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_speed_q <= tals_pkg::RST_MAX_SPEED;
    end else if (cmd_i.restore) begin
      cur_speed_q <= max_q;
    end else if (cmd_i.ramp_set) begin
      unique case (mode_q)
        RM_DWELL: cur_speed_q <= tals_pkg::at_least_one(dwell_q);
        RM_MAX:   cur_speed_q <= hi;
        RM_RAMP:  cur_speed_q <= ramp_sum[tals_pkg::SPEED_W-1:0];
        RM_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      tgt1_q <= target_first_i;
      tgt2_q <= target_second_i;
    end
    if (cmd_i.calc_dist) begin
      dist1_q   <= d1[tals_pkg::POS_W] ? nd1[tals_pkg::POS_W-1:0] : d1[tals_pkg::POS_W-1:0];
      dist2_q   <= d2[tals_pkg::POS_W] ? nd2[tals_pkg::POS_W-1:0] : d2[tals_pkg::POS_W-1:0];
      dir_new_q <= {~d2[tals_pkg::POS_W], ~d1[tals_pkg::POS_W]};
    end
    if (cmd_i.accum) begin
      err_sum_q <= err_q + tals_pkg::pos_ext_t'(minor_q);
      rem_q     <= major_q - idx_q;
      up_q      <= (idx_q <= tals_pkg::pos_t'(len));
      short_q   <= (major_q < tals_pkg::pos_t'(sd_q));
    end
    if (cmd_i.classify) begin
      mode_q    <= mode_d;
      k_q       <= k_d;
      neg_q     <= neg_d;
      absdiff_q <= absdiff_d;
    end
    if (cmd_i.mul) begin
      div_quo_q <= tals_pkg::prod_t'(absdiff_q) * tals_pkg::prod_t'(k_q);
      div_rem_q <= '0;
      div_cnt_q <= tals_pkg::DIV_CNT_LAST;
    end else if (cmd_i.div_step) begin
      div_rem_q <= trial_ge ? (trial - tals_pkg::len_ext_t'(len)) : trial;
      div_quo_q <= {div_quo_q[tals_pkg::PROD_W-2:0], trial_ge};
      div_cnt_q <= div_cnt_q - tals_pkg::div_cnt_t'(1);
    end
    if (cmd_i.step) begin
      step1_q <= s1;
      step2_q <= s2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_step1_q  <= cmd_i.out_steps & step1_q;
      out_step2_q  <= cmd_i.out_steps & step2_q;
      out_dir1_q   <= dirs_q[0];
      out_dir2_q   <= dirs_q[1];
      out_speed_q  <= tals_pkg::at_least_one(cur_speed_q);
      out_status_q <= cmd_i.out_status;
    end
  end

  always_comb begin
    sts_o.major_zero  = (major_q == '0);
    sts_o.ramp_needed = (mode_d == RM_RAMP);
    sts_o.div_last    = (div_cnt_q == '0);
    sts_o.last_step   = (rem_q == tals_pkg::POS_ONE);
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  assign out_valid_o       = out_valid_q;
  assign out_step_first_o  = out_step1_q;
  assign out_step_second_o = out_step2_q;
  assign out_dir_first_o   = out_dir1_q;
  assign out_dir_second_o  = out_dir2_q;
  assign out_speed_o       = out_speed_q;
  assign out_status_o      = out_status_q;

  `TALS_ASSERT(a_err_below_major, clk_i, rst_ni, (major_q == '0) || (err_q < tals_pkg::pos_ext_t'(major_q)), "Bresenham error reached the major length")
  `TALS_ASSERT_IMPL(a_div_nonzero_len, clk_i, rst_ni, cmd_i.div_step, len != '0, "ramp division by a zero ramp length")

endmodule

>>> rtl/two_axis_line_stepper_with_ramp.sv
// Top level of the two-axis straight-line stepper with a trapezoidal speed ramp.
// The block takes one transaction at a time and presents one result transaction for each.
// An accepted start passes through distance, select and start-end states; a start rejected
// while busy or a tick while idle goes straight to the result. A tick on the plateau, at a
// dwell move or with ramping off passes through accumulate, classify, ramp set and step, and
// a tick in a ramp section also through a multiply and the bit-serial divider that computes
// the ramp quotient one bit per cycle. The next transaction is accepted in the cycle after
// the result enters the output register, which holds it until it is taken.
module two_axis_line_stepper_with_ramp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  tals_pkg::cfg_idx_t  cfg_idx_i,
  input  tals_pkg::cfg_data_t cfg_data_i,
  tals_in_if.sink             item_i,
  tals_out_if.source          result_o
);

  tals_pkg::dp_cmd_t cmd;
  tals_pkg::dp_sts_t sts;
  logic              in_ready;

  tals_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_opcode_i (item_i.opcode),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tals_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .target_first_i    (item_i.target_first),
    .target_second_i   (item_i.target_second),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (result_o.valid),
    .out_ready_i       (result_o.ready),
    .out_step_first_o  (result_o.step_first),
    .out_step_second_o (result_o.step_second),
    .out_dir_first_o   (result_o.dir_first),
    .out_dir_second_o  (result_o.dir_second),
    .out_speed_o       (result_o.speed),
    .out_status_o      (result_o.status)
  );

  assign item_i.ready = in_ready;

endmodule

>>> test/two_axis_line_stepper_with_ramp_test.sv
// Self-checking testbench of the two-axis line stepper with its speed ramp.
`timescale 1ns / 1ps

module two_axis_line_stepper_with_ramp_test;
  import tals_pkg::*;

  localparam int       CYCLE_LIMIT    = 800000;
  localparam int       SETTLE_CYCLES  = 40;
  localparam int       PHASE_ITEMS    = 125;
  localparam int       RANDOM_PHASES  = 2;
  localparam cfg_idx_t UNUSED_REG_IDX = cfg_idx_t'(7);
  localparam tgt_t     TGT_MAX        = 24'h7FFFFF;
  localparam tgt_t     TGT_MIN        = 24'h800000;

  typedef struct packed {
    logic    step_first;
    logic    step_second;
    logic    dir_first;
    logic    dir_second;
    speed_t  speed;
    status_e status;
  } step_result_t;

  typedef struct {
    opcode_e      op;
    tgt_t         first_tgt;
    tgt_t         second_tgt;
    bit           typed;
    step_result_t known;
  } directed_row_t;

  typedef struct {
    bit     ramp;
    speed_t top;
    speed_t base;
    speed_t dwell;
    dist_t  threshold;
    bit     calm;
  } ramp_setting_t;

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  cfg_idx_t  cfg_idx_i;
  cfg_data_t cfg_data_i;

  tals_in_if  item_bus ();
  tals_out_if result_bus ();

  two_axis_line_stepper_with_ramp dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_bus.sink),
    .result_o   (result_bus.source)
  );

  directed_row_t directed_rows [21] = '{
    '{OP_TICK,  '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, RST_MAX_SPEED, STATUS_IDLE}},
    '{OP_START, '0, '0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, RST_MAX_SPEED, STATUS_IDLE}},
    '{OP_START, tgt_t'(3), tgt_t'(-2), 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, RST_MAX_SPEED, STATUS_STEPPING}},
    '{OP_START, TGT_MAX, TGT_MIN, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b0, RST_MAX_SPEED, STATUS_REJECTED}},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, RST_MAX_SPEED, STATUS_IDLE}},
    '{OP_START, tgt_t'(6), tgt_t'(1), 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, RST_MAX_SPEED, STATUS_STEPPING}},
    '{OP_START, TGT_MIN, TGT_MAX, 1'b1,
      '{1'b0, 1'b0, 1'b1, 1'b1, RST_MAX_SPEED, STATUS_REJECTED}},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_START, '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, RST_MAX_SPEED, STATUS_STEPPING}},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b0, '0},
    '{OP_TICK,  '0, '0, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, RST_MAX_SPEED, STATUS_IDLE}}
  };

  ramp_setting_t settings [10] = '{
    '{1'b1, 16'd1000,  16'd100,   16'd100,   16'd8,     1'b0},
    '{1'b1, 16'd65535, 16'd1,     16'd65535, 16'd20,    1'b0},
    '{1'b1, 16'd1,     16'd65535, 16'd1,     16'd12,    1'b0},
    '{1'b0, 16'd5000,  16'd300,   16'd77,    16'd6,     1'b1},
    '{1'b1, 16'd0,     16'd0,     16'd0,     16'd10,    1'b0},
    '{1'b0, 16'd0,     16'd7,     16'd9,     16'd3,     1'b0},
    '{1'b1, 16'd40000, 16'd2000,  16'd500,   16'd0,     1'b0},
    '{1'b1, 16'd3000,  16'd200,   16'd50,    16'd1,     1'b1},
    '{1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 1'b0},
    '{1'b1, 16'd777,   16'd12345, 16'd3,     16'd33,    1'b0}
  };

  logic     ramp_on;
  speed_t   top_speed;
  speed_t   base_speed;
  speed_t   dwell_level;
  dist_t    short_len;
  pos_t     pos_first;
  pos_t     pos_second;
  pos_t     major_len;
  pos_t     minor_len;
  pos_ext_t error_sum;
  pos_t     step_count;
  logic     second_major;
  logic     dir_first_q;
  logic     dir_second_q;
  logic     moving;
  speed_t   speed_now;

  step_result_t expected_steps [$];
  bit           calm;
  int           mismatches;
  int           results_checked;
  int           items_sent;
  int           moves_started;
  int           ramp_ticks;
  int           rejected_starts;
  int           settings_used;
  int           cycle_count;

  function automatic speed_t raise_zero(speed_t v);
    return (v == '0) ? speed_t'(1) : v;
  endfunction

  function automatic void update_ramp_speed();
    longint hi, lo, half, idx, major, num, quot;
    hi    = raise_zero(top_speed);
    lo    = raise_zero(base_speed);
    half  = short_len / 2;
    idx   = step_count;
    major = major_len;
    if (major < longint'(short_len)) begin
      if (idx == 0) speed_now = raise_zero(dwell_level);
      return;
    end
    ramp_ticks++;
    if (half == 0) begin
      speed_now = speed_t'(hi);
      return;
    end
    if (idx <= half) begin
      num = (hi - lo) * idx;
    end else if (idx >= major - half) begin
      num = (hi - lo) * (major - idx);
    end else begin
      return;
    end
    quot = num / half;
    if ((num % half) != 0 && num < 0) quot--;
    quot += lo;
    if (quot < 1) quot = 1;
    speed_now = speed_t'(quot);
  endfunction

  function automatic step_result_t advance_stepper(opcode_e op, tgt_t first_tgt,
                                                   tgt_t second_tgt);
    step_result_t res;
    longint       d1, d2, a1, a2;
    logic         minor_step;
    speed_t       shown;
    res        = '0;
    minor_step = 1'b0;
    if (op == OP_START) begin
      if (moving) begin
        res.status = STATUS_REJECTED;
        rejected_starts++;
      end else begin
        d1 = longint'(first_tgt) - longint'(spos_t'(pos_first));
        d2 = longint'(second_tgt) - longint'(spos_t'(pos_second));
        a1 = (d1 < 0) ? -d1 : d1;
        a2 = (d2 < 0) ? -d2 : d2;
        dir_first_q  = (d1 >= 0);
        dir_second_q = (d2 >= 0);
        if (a1 > a2) begin
          second_major = 1'b0;
          major_len    = pos_t'(a1);
          minor_len    = pos_t'(a2);
        end else begin
          second_major = 1'b1;
          major_len    = pos_t'(a2);
          minor_len    = pos_t'(a1);
        end
        error_sum  = '0;
        step_count = '0;
        if (major_len == '0) begin
          speed_now  = top_speed;
          res.status = STATUS_IDLE;
        end else begin
          moving     = 1'b1;
          res.status = STATUS_STEPPING;
          moves_started++;
        end
      end
      shown = speed_now;
    end else if (moving) begin
      if (ramp_on) update_ramp_speed();
      error_sum = error_sum + minor_len;
      if (error_sum >= major_len) begin
        error_sum  = error_sum - major_len;
        minor_step = 1'b1;
      end
      res.step_first  = second_major ? minor_step : 1'b1;
      res.step_second = second_major ? 1'b1 : minor_step;
      if (res.step_first) pos_first = dir_first_q ? pos_first + 1'b1 : pos_first - 1'b1;
      if (res.step_second) pos_second = dir_second_q ? pos_second + 1'b1 : pos_second - 1'b1;
      step_count = step_count + 1'b1;
      shown      = speed_now;
      if (step_count >= major_len) begin
        moving     = 1'b0;
        res.status = STATUS_LAST;
        speed_now  = top_speed;
      end else begin
        res.status = STATUS_STEPPING;
      end
    end else begin
      shown      = speed_now;
      res.status = STATUS_IDLE;
    end
    res.dir_first  = dir_first_q;
    res.dir_second = dir_second_q;
    res.speed      = raise_zero(shown);
    return res;
  endfunction

  function automatic int pause_length();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_major_len();
    int s, r;
    s = int'(short_len);
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (s > 1 && s <= 400 && r < 70) return $urandom_range(s, s + s / 2 + 6);
    if (s > 1 && s <= 400) return $urandom_range(1, s - 1);
    return $urandom_range(1, 40);
  endfunction

  task automatic send_item(opcode_e op, tgt_t first_tgt, tgt_t second_tgt,
                           bit typed = 1'b0, step_result_t known = '0);
    int           gap;
    step_result_t predicted;
    gap = pause_length();
    if (gap > 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item_bus.valid         <= 1'b1;
    item_bus.opcode        <= op;
    item_bus.target_first  <= first_tgt;
    item_bus.target_second <= second_tgt;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    predicted = advance_stepper(op, first_tgt, second_tgt);
    expected_steps.push_back(typed ? known : predicted);
    items_sent++;
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (cfg_idx_e'(idx))
      REG_RAMP_ENABLE:    ramp_on     = data[0];
      REG_MAX_SPEED:      top_speed   = speed_t'(data);
      REG_START_SPEED:    base_speed  = speed_t'(data);
      REG_DWELL_SPEED:    dwell_level = speed_t'(data);
      REG_SHORT_DISTANCE: short_len   = dist_t'(data);
      default: ;
    endcase
  endtask

  task automatic apply_setting(ramp_setting_t s);
    write_reg(REG_RAMP_ENABLE, cfg_data_t'(s.ramp));
    write_reg(REG_MAX_SPEED, s.top);
    write_reg(UNUSED_REG_IDX, cfg_data_t'($urandom));
    write_reg(REG_START_SPEED, s.base);
    write_reg(REG_DWELL_SPEED, s.dwell);
    write_reg(REG_SHORT_DISTANCE, s.threshold);
    cfg_we_i <= 1'b0;
    calm = s.calm;
    settings_used++;
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_move();
    int     len_major, len_minor, r;
    longint d_major, d_minor, t1, t2;
    bit     swap;
    len_major = pick_major_len();
    r = $urandom_range(0, 99);
    if (r < 15) len_minor = len_major;
    else if (r < 30) len_minor = 0;
    else len_minor = $urandom_range(0, len_major);
    d_major = $urandom_range(0, 1) ? len_major : -len_major;
    d_minor = $urandom_range(0, 1) ? len_minor : -len_minor;
    swap    = $urandom_range(0, 1);
    t1 = longint'(spos_t'(pos_first)) + (swap ? d_minor : d_major);
    t2 = longint'(spos_t'(pos_second)) + (swap ? d_major : d_minor);
    send_item(OP_START, tgt_t'(t1), tgt_t'(t2));
    while (moving) begin
      if ($urandom_range(0, 99) < 4) send_item(OP_START, tgt_t'($urandom), tgt_t'($urandom));
      send_item(OP_TICK, tgt_t'($urandom), tgt_t'($urandom));
    end
    if ($urandom_range(0, 99) < 8) send_item(OP_TICK, tgt_t'($urandom), tgt_t'($urandom));
  endtask

  task automatic run_phase();
    int phase_end;
    phase_end = items_sent + PHASE_ITEMS;
    while (items_sent < phase_end) run_move();
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                 name, results_checked, want, got);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int hold;
    hold = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
        result_bus.ready <= 1'b0;
      end else begin
        hold = pause_length();
        result_bus.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Result transaction arrived with nothing outstanding");
      end else begin
        want = expected_steps.pop_front();
        check_field("step_first", want.step_first, result_bus.step_first);
        check_field("step_second", want.step_second, result_bus.step_second);
        check_field("dir_first", want.dir_first, result_bus.dir_first);
        check_field("dir_second", want.dir_second, result_bus.dir_second);
        check_field("speed", want.speed, result_bus.speed);
        check_field("status", want.status, result_bus.status);
      end
      results_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d results outstanding", expected_steps.size());
      $display("** two_axis_line_stepper_with_ramp: FAILED **");
      $finish;
    end
  end

  initial begin
    ramp_setting_t wild;
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= '0;
    cfg_data_i             <= '0;
    item_bus.valid         <= 1'b0;
    item_bus.opcode        <= OP_TICK;
    item_bus.target_first  <= '0;
    item_bus.target_second <= '0;
    ramp_on      = 1'b1;
    top_speed    = RST_MAX_SPEED;
    base_speed   = RST_START_SPEED;
    dwell_level  = RST_DWELL_SPEED;
    short_len    = RST_SHORT_DIST;
    pos_first    = '0;
    pos_second   = '0;
    major_len    = '0;
    minor_len    = '0;
    error_sum    = '0;
    step_count   = '0;
    second_major = 1'b0;
    dir_first_q  = 1'b0;
    dir_second_q = 1'b0;
    moving       = 1'b0;
    speed_now    = RST_MAX_SPEED;
    calm         = 1'b1;
    settings_used = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k]) begin
      send_item(directed_rows[k].op, directed_rows[k].first_tgt, directed_rows[k].second_tgt,
                directed_rows[k].typed, directed_rows[k].known);
    end
    calm = 1'b0;
    run_phase();

    foreach (settings[k]) begin
      settle();
      apply_setting(settings[k]);
      run_phase();
    end

    repeat (RANDOM_PHASES) begin
      settle();
      wild.ramp      = $urandom_range(0, 1);
      wild.top       = speed_t'($urandom);
      wild.base      = speed_t'($urandom);
      wild.dwell     = speed_t'($urandom);
      wild.threshold = dist_t'($urandom_range(0, 30));
      wild.calm      = 1'b0;
      apply_setting(wild);
      run_phase();
    end

    settle();
    $display("Checked %0d result transactions for %0d input transactions under %0d settings.",
             results_checked, items_sent, settings_used);
    $display("Moves started: %0d, ramped ticks: %0d, starts rejected while busy: %0d.",
             moves_started, ramp_ticks, rejected_starts);
    if (mismatches == 0) begin
      $display("** two_axis_line_stepper_with_ramp: PASSED **");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("** two_axis_line_stepper_with_ramp: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tals_pkg.sv
rtl/tals_if.sv
rtl/tals_ctrl.sv
rtl/tals_dp.sv
rtl/two_axis_line_stepper_with_ramp.sv
test/two_axis_line_stepper_with_ramp_test.sv
